### rtl/pvm_pkg.sv
// Shared definitions for the partition volume map: op and status codes,
// sequencer states and default sizing. No dependencies.
package pvm_pkg;

  localparam int MaxVolsDefault = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ENTRY  = 2'd1;
  localparam logic [1:0] OP_ACCESS = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_GUID = 3'd1;
  localparam logic [2:0] ST_ZERO_LBAS = 3'd2;
  localparam logic [2:0] ST_INVERTED  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_BAD_VOL   = 3'd5;
  localparam logic [2:0] ST_OOB       = 3'd6;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUB  = 7'b0000010,
    S_INC  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_ABS  = 7'b0100000,
    S_DONE = 7'b1000000
  } pvm_state_t;

endpackage

### rtl/pvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/partition_volume_map_core.sv
// Partition volume map top level: sequencer around one shared 65-bit adder
// and a start/size table held in pvm_ram. Depends on pvm_pkg and pvm_ram.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | op, GUID, LBAs, index, offset, count, dir
//  out_    | output    | out_valid/out_stall | status, slot, size, drive LBA, dir, count
//
// Clear and unused ops go straight to the final step; entry runs subtract and
// increment, access runs sum, compare and absolute (a bad volume index ends
// after the sum). A finished result is held in the output register, so the
// next item is taken while it waits; the sequencer holds in its last step
// only when the output register is still full and stalled. Reset is
// synchronous, active low, and empties the table at once.
module partition_volume_map_core
  import pvm_pkg::*;
#(
  parameter int MAX_VOLS = MaxVolsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_type_guid_high,
  input  logic [63:0] in_type_guid_low,
  input  logic [63:0] in_first_lba,
  input  logic [63:0] in_last_lba,
  input  logic [7:0]  in_volume_index,
  input  logic [63:0] in_relative_lba,
  input  logic [15:0] in_sector_count,
  input  logic        in_is_write,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_assigned_volume,
  output logic [63:0] out_volume_size,
  output logic [63:0] out_drive_lba,
  output logic        out_write_out,
  output logic [4:0]  out_volumes_held
);

  localparam int AW = (MAX_VOLS > 1) ? $clog2(MAX_VOLS) : 1;
  localparam int TW = $clog2(MAX_VOLS + 1);
  localparam logic [TW-1:0] MaxVolsT = TW'(MAX_VOLS);

  pvm_state_t  state_r, state_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [1:0]  op_r;
  logic [63:0] ghi_r, glo_r, first_r, last_r, rel_r;
  logic [7:0]  idx_r;
  logic [15:0] cnt_r;
  logic        wr_r;
  logic [2:0]  status_r, status_nxt;
  logic [64:0] acc_r, acc_nxt;

  logic [2:0]  ostatus_r;
  logic [3:0]  oslot_r;
  logic [63:0] osize_r, oabs_r;
  logic        owr_r;
  logic [4:0]  oheld_r;

  logic [64:0] alu_a, alu_b;
  logic        alu_cin;
  logic [65:0] alu_res;

  logic        ram_we;
  logic [127:0] ram_rdata;
  logic        in_acc, load_out, bad_vol, entry_ok, access_ok;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign bad_vol  = 9'(idx_r) >= 9'(total_r);
  assign entry_ok = (op_r == OP_ENTRY) && (status_r == ST_OK);
  assign access_ok = (op_r == OP_ACCESS) && (status_r == ST_OK);
  assign ram_we   = load_out && entry_ok;

  pvm_ram #(
    .WIDTH(128),
    .DEPTH(MAX_VOLS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(total_r[AW-1:0]),
    .wdata({first_r, acc_r[63:0]}),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_r)
      S_SUB: begin
        alu_a   = {1'b0, last_r};
        alu_b   = ~{1'b0, first_r};
        alu_cin = 1'b1;
      end
      S_INC: begin
        alu_a   = {1'b0, acc_r[63:0]};
        alu_cin = 1'b1;
      end
      S_SUM: begin
        alu_a = {1'b0, rel_r};
        alu_b = {49'd0, cnt_r};
      end
      S_CMP: begin
        alu_a   = {1'b0, ram_rdata[63:0]};
        alu_b   = ~acc_r;
        alu_cin = 1'b1;
      end
      S_ABS: begin
        alu_a = {1'b0, ram_rdata[127:64]};
        alu_b = {1'b0, rel_r};
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, alu_b} + {65'd0, alu_cin};
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    acc_nxt    = acc_r;
    total_nxt  = total_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          case (in_op)
            OP_ENTRY:  state_nxt = S_SUB;
            OP_ACCESS: state_nxt = S_SUM;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SUB: begin
        acc_nxt = alu_res[64:0];
        if ((ghi_r | glo_r) == 64'd0) begin
          status_nxt = ST_ZERO_GUID;
        end else if ((first_r | last_r) == 64'd0) begin
          status_nxt = ST_ZERO_LBAS;
        end else if (!alu_res[65]) begin
          status_nxt = ST_INVERTED;
        end else if (total_r >= MaxVolsT) begin
          status_nxt = ST_FULL;
        end
        state_nxt = S_INC;
      end
      S_INC: begin
        acc_nxt   = alu_res[64:0];
        state_nxt = S_DONE;
      end
      S_SUM: begin
        acc_nxt = alu_res[64:0];
        if (bad_vol) begin
          status_nxt = ST_BAD_VOL;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!alu_res[65]) begin
          status_nxt = ST_OOB;
        end
        state_nxt = S_ABS;
      end
      S_ABS: begin
        acc_nxt   = alu_res[64:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          if (op_r == OP_CLEAR) begin
            total_nxt = '0;
          end else if (entry_ok) begin
            total_nxt = total_r + TW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    acc_r    <= acc_nxt;
    if (in_acc) begin
      op_r    <= in_op;
      ghi_r   <= in_type_guid_high;
      glo_r   <= in_type_guid_low;
      first_r <= in_first_lba;
      last_r  <= in_last_lba;
      idx_r   <= in_volume_index;
      rel_r   <= in_relative_lba;
      cnt_r   <= in_sector_count;
      wr_r    <= in_is_write;
    end
    if (load_out) begin
      ostatus_r <= status_r;
      oslot_r   <= entry_ok ? 4'(total_r) : 4'd0;
      osize_r   <= entry_ok ? acc_r[63:0] : 64'd0;
      oabs_r    <= access_ok ? acc_r[63:0] : 64'd0;
      owr_r     <= access_ok ? wr_r : 1'b0;
      oheld_r   <= 5'(total_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = ostatus_r;
  assign out_assigned_volume = oslot_r;
  assign out_volume_size     = osize_r;
  assign out_drive_lba       = oabs_r;
  assign out_write_out       = owr_r;
  assign out_volumes_held    = oheld_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MaxVolsT)
    else $error("volume count exceeds table depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (total_r < MaxVolsT))
    else $error("table write with no free slot");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the final step");

  a_entry_starts_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_ENTRY) |=> (state_r == S_SUB))
    else $error("entry beat did not start the subtract step");

endmodule
